[hdl/lkvc_pkg.sv]
// Shared types and constants for the LRU key-value cache.
// Used by the controller, the datapath and the top level; depends on nothing.
package lkvc_pkg;

   localparam int KEY_W   = 64;
   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;
   localparam int OCC_W   = 5;

   localparam logic CMD_GET    = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
   localparam logic [VALUE_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic load;
      logic lookup;
      logic commit;
   } ctrl_type;

endpackage

[hdl/lru_key_value_cache_core.sv]
// Top level of the LRU key-value cache: controller plus datapath.
// Depends on lkvc_pkg, lkvc_controller and lkvc_datapath.
//
// A request beat (req_cmd, req_key, req_value) is taken at a rising edge where
// start is high and busy is low. req_cmd selects a get or an insert/update.
// Each request yields exactly one result beat on the rsp_ ports, marked by
// rsp_strobe for a single cycle; the receiver always takes it and cannot stall.
// The result is formed in the LOOKUP state, with the parallel key compare over
// all entries and the memory read, then in the UPDATE state, with the recency
// update and the entry write. busy is high only during the compare cycle, so a new
// request can be accepted during the update of the previous one, not its compare.
// csr_wr_en and csr_wr_data write the capacity register; the user must write it
// only while no request is in flight, which the block itself does not enforce.
// Reset clears all entries, the occupancy and the result strobe, and sets
// capacity to 16. No clearing pass is needed after reset.
module lru_key_value_cache_core #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_cmd,
   input  logic [lkvc_pkg::KEY_W-1:0]           req_key,
   input  logic signed [lkvc_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_strobe,
   output logic                                 rsp_hit,
   output logic signed [lkvc_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic                                 rsp_evicted,
   output logic [lkvc_pkg::KEY_W-1:0]           rsp_evicted_key,
   output logic signed [lkvc_pkg::VALUE_W-1:0]  rsp_evicted_value,
   output logic [lkvc_pkg::OCC_W-1:0]           rsp_occupancy,
   input  logic                                 csr_wr_en,
   input  logic [lkvc_pkg::CAP_W-1:0]           csr_wr_data
);

   lkvc_pkg::ctrl_type ctrl;

   lkvc_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   lkvc_datapath #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .req_cmd           (req_cmd),
      .req_key           (req_key),
      .req_value         (req_value),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_hit           (rsp_hit),
      .rsp_read_value    (rsp_read_value),
      .rsp_evicted       (rsp_evicted),
      .rsp_evicted_key   (rsp_evicted_key),
      .rsp_evicted_value (rsp_evicted_value),
      .rsp_occupancy     (rsp_occupancy)
   );

endmodule

[hdl/lkvc_controller.sv]
// Sequencing state machine of the LRU key-value cache.
// Depends on lkvc_pkg for the command struct sent to the datapath.
module lkvc_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output lkvc_pkg::ctrl_type ctrl
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy   = (state_ff == ST_LOOKUP);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = start ? ST_LOOKUP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign ctrl.load   = accept;
   assign ctrl.lookup = (state_ff == ST_LOOKUP);
   assign ctrl.commit = (state_ff == ST_UPDATE);

   a_lookup_then_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) |=> (state_ff == ST_UPDATE))
      else $error("lookup was not followed by an update");

endmodule

[hdl/lkvc_datapath.sv]
// Key compare lanes, recency ranks, entry memory and result registers of the cache.
// Driven by commands from lkvc_controller; depends on lkvc_pkg.
module lkvc_datapath #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lkvc_pkg::ctrl_type                   ctrl,
   input  logic                                 req_cmd,
   input  logic [lkvc_pkg::KEY_W-1:0]           req_key,
   input  logic signed [lkvc_pkg::VALUE_W-1:0]  req_value,
   input  logic                                 csr_wr_en,
   input  logic [lkvc_pkg::CAP_W-1:0]           csr_wr_data,
   output logic                                 rsp_strobe,
   output logic                                 rsp_hit,
   output logic signed [lkvc_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic                                 rsp_evicted,
   output logic [lkvc_pkg::KEY_W-1:0]           rsp_evicted_key,
   output logic signed [lkvc_pkg::VALUE_W-1:0]  rsp_evicted_value,
   output logic [lkvc_pkg::OCC_W-1:0]           rsp_occupancy
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int KW    = lkvc_pkg::KEY_W;
   localparam int VW    = lkvc_pkg::VALUE_W;
   localparam int OW    = lkvc_pkg::OCC_W;
   localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;
   localparam int MEM_W = KEY_BITS + VW;

   logic                       req_cmd_ff;
   logic [KEY_BITS-1:0]        req_key_ff;
   logic [VW-1:0]              req_value_ff;
   logic [lkvc_pkg::CAP_W-1:0] capacity_ff;

   logic [KEY_BITS-1:0] key_ff [ENTRIES];
   logic [IDX_W-1:0]    age_ff [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff;
   logic [CNT_W-1:0]    count_ff;

   logic [MEM_W-1:0] entry_mem [ENTRIES];
   logic [MEM_W-1:0] rd_data_ff;

   logic             hit_ff;
   logic             evict_ff;
   logic [IDX_W-1:0] slot_ff;
   logic [IDX_W-1:0] hit_age_ff;

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] evict_match;
   logic               found_any;
   logic               free_any;
   logic [IDX_W-1:0]   found_idx;
   logic [IDX_W-1:0]   found_age;
   logic [IDX_W-1:0]   evict_idx;
   logic [IDX_W-1:0]   free_idx;
   logic [IDX_W-1:0]   oldest_age;
   logic [IDX_W-1:0]   slot_in;
   logic [CMP_W-1:0]   eff_cap;
   logic               full;

   logic               alloc;
   logic [VW-1:0]      rd_value;
   logic [KEY_BITS-1:0] rd_key;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_cmd_ff   <= req_cmd;
         req_key_ff   <= req_key[KEY_BITS-1:0];
         req_value_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) capacity_ff <= lkvc_pkg::CAP_RESET;
      else if (csr_wr_en) capacity_ff <= csr_wr_data;
   end

   always_comb begin
      eff_cap = CMP_W'(capacity_ff);
      if (capacity_ff == '0) eff_cap = CMP_W'(1);
      if (eff_cap > CMP_W'(ENTRIES)) eff_cap = CMP_W'(ENTRIES);
   end

   assign full       = (CMP_W'(count_ff) >= eff_cap);
   assign oldest_age = IDX_W'(count_ff - 1'b1);

   always_comb begin
      found_idx = '0;
      found_age = '0;
      evict_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]       = valid_ff[i] && (key_ff[i] == req_key_ff);
         evict_match[i] = valid_ff[i] && (age_ff[i] == oldest_age);
         found_idx      = found_idx | (match[i] ? IDX_W'(i) : '0);
         found_age      = found_age | (match[i] ? age_ff[i] : '0);
         evict_idx      = evict_idx | (evict_match[i] ? IDX_W'(i) : '0);
      end
   end

   assign found_any = |match;
   assign free_any  = ~&valid_ff;

   always_comb begin
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_idx = IDX_W'(i);
      end
   end

   always_comb begin
      if (found_any) slot_in = found_idx;
      else if (full) slot_in = evict_idx;
      else slot_in = free_idx;
   end

   always_ff @(posedge clock) begin
      if (ctrl.lookup) begin
         hit_ff     <= found_any;
         evict_ff   <= full;
         slot_ff    <= slot_in;
         hit_age_ff <= found_age;
         rd_data_ff <= entry_mem[slot_in];
      end
   end

   assign alloc    = (req_cmd_ff == lkvc_pkg::CMD_INSERT) && !hit_ff;
   assign rd_value = rd_data_ff[VW-1:0];
   assign rd_key   = rd_data_ff[MEM_W-1:VW];

   always_ff @(posedge clock) begin
      if (ctrl.commit && (req_cmd_ff == lkvc_pkg::CMD_INSERT)) begin
         entry_mem[slot_ff] <= {req_key_ff, req_value_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit && alloc) key_ff[slot_ff] <= req_key_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) age_ff[i] <= '0;
      end else if (ctrl.commit) begin
         if (hit_ff) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (IDX_W'(i) == slot_ff) age_ff[i] <= '0;
               else if (valid_ff[i] && (age_ff[i] < hit_age_ff))
                  age_ff[i] <= IDX_W'(age_ff[i] + 1'b1);
            end
         end else if (alloc) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (IDX_W'(i) == slot_ff) age_ff[i] <= '0;
               else if (valid_ff[i]) age_ff[i] <= IDX_W'(age_ff[i] + 1'b1);
            end
            valid_ff[slot_ff] <= 1'b1;
            if (!evict_ff) count_ff <= CNT_W'(count_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else rsp_strobe <= ctrl.commit;
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         rsp_hit <= hit_ff;
         if (req_cmd_ff == lkvc_pkg::CMD_GET)
            rsp_read_value <= hit_ff ? rd_value : lkvc_pkg::MISS_VALUE;
         else
            rsp_read_value <= '0;
         rsp_evicted       <= alloc && evict_ff;
         rsp_evicted_key   <= (alloc && evict_ff) ? KW'(rd_key) : '0;
         rsp_evicted_value <= (alloc && evict_ff) ? rd_value : '0;
         if (alloc && !evict_ff) rsp_occupancy <= OW'(CNT_W'(count_ff + 1'b1));
         else rsp_occupancy <= OW'(count_ff);
      end
   end

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      ($countones(valid_ff) == int'(count_ff)))
      else $error("valid count disagrees with the valid bits");

   a_one_oldest: assert property (@(posedge clock) disable iff (reset)
      (ctrl.lookup && (req_cmd_ff == lkvc_pkg::CMD_INSERT) && !found_any && full)
      |-> $onehot(evict_match))
      else $error("no unique least recent entry to evict");

   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      (ctrl.lookup && (req_cmd_ff == lkvc_pkg::CMD_INSERT) && !found_any && !full)
      |-> free_any)
      else $error("allocation without a free entry");

   a_strobe_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(ctrl.commit))
      else $error("result beat without an update");

endmodule

[dv/lru_key_value_cache_core_tb.sv]
// Self-checking testbench for lru_key_value_cache_core: directed and random get/insert beats
// checked against an internal LRU cache predictor, across several capacity settings.
// Depends on lkvc_pkg and the lru_key_value_cache_core RTL.
module lru_key_value_cache_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_W   = lkvc_pkg::KEY_W;
   localparam int VALUE_W = lkvc_pkg::VALUE_W;
   localparam int OCC_W   = lkvc_pkg::OCC_W;
   localparam int CAP_W   = lkvc_pkg::CAP_W;

   localparam int CACHE_ENTRIES = 16;
   localparam int KEY_POOL_SIZE = 24;
   localparam int DRAIN_LIMIT   = 200;

   typedef struct packed {
      logic                 hit;
      logic [VALUE_W-1:0]   read_value;
      logic                 evicted;
      logic [KEY_W-1:0]     evicted_key;
      logic [VALUE_W-1:0]   evicted_value;
      logic [OCC_W-1:0]     occupancy;
   } cache_result_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic                       req_cmd;
   logic [KEY_W-1:0]           req_key;
   logic signed [VALUE_W-1:0]  req_value;
   logic                       rsp_strobe;
   logic                       rsp_hit;
   logic signed [VALUE_W-1:0]  rsp_read_value;
   logic                       rsp_evicted;
   logic [KEY_W-1:0]           rsp_evicted_key;
   logic signed [VALUE_W-1:0]  rsp_evicted_value;
   logic [OCC_W-1:0]           rsp_occupancy;
   logic                       csr_wr_en;
   logic [CAP_W-1:0]           csr_wr_data;

   // Predictor state.
   logic [KEY_W-1:0]   cache_key [CACHE_ENTRIES];
   logic [VALUE_W-1:0] cache_value [CACHE_ENTRIES];
   bit                 cache_valid [CACHE_ENTRIES];
   int                 cache_age [CACHE_ENTRIES];
   int                 cache_count;
   logic [CAP_W-1:0]   cache_capacity;

   cache_result_type   pending_results[$];
   logic [KEY_W-1:0]   key_pool [KEY_POOL_SIZE];

   int error_count;
   int result_count;
   int hit_count;
   int eviction_count;
   int capacity_writes;
   int burst_left;

   cache_result_type want;
   cache_result_type got;

   lru_key_value_cache_core #(
      .ENTRIES  (CACHE_ENTRIES),
      .KEY_BITS (KEY_W)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_key           (req_key),
      .req_value         (req_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_hit           (rsp_hit),
      .rsp_read_value    (rsp_read_value),
      .rsp_evicted       (rsp_evicted),
      .rsp_evicted_key   (rsp_evicted_key),
      .rsp_evicted_value (rsp_evicted_value),
      .rsp_occupancy     (rsp_occupancy),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("lru_key_value_cache_core: mismatch");
      $finish;
   end

   function automatic int effective_capacity();
      int c;
      c = int'(cache_capacity);
      if (c == 0) c = 1;
      if (c > CACHE_ENTRIES) c = CACHE_ENTRIES;
      return c;
   endfunction

   function automatic cache_result_type predict_access(logic cmd, logic [KEY_W-1:0] key,
                                                       logic [VALUE_W-1:0] value);
      cache_result_type res;
      int found;
      int slot;
      int oldest;
      int a;
      res = '0;
      found = -1;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         if (found < 0 && cache_valid[i] && cache_key[i] == key) found = i;
      end
      if (found >= 0) begin
         res.hit = 1'b1;
         if (cmd == lkvc_pkg::CMD_GET) res.read_value = cache_value[found];
         else cache_value[found] = value;
         a = cache_age[found];
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (cache_valid[i] && cache_age[i] < a) cache_age[i]++;
         end
         cache_age[found] = 0;
      end else if (cmd == lkvc_pkg::CMD_GET) begin
         res.read_value = lkvc_pkg::MISS_VALUE;
      end else begin
         slot = -1;
         if (cache_count >= effective_capacity()) begin
            oldest = 0;
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
               if (cache_valid[i] && (slot < 0 || cache_age[i] > oldest)) begin
                  slot = i;
                  oldest = cache_age[i];
               end
            end
            if (slot >= 0) begin
               res.evicted       = 1'b1;
               res.evicted_key   = cache_key[slot];
               res.evicted_value = cache_value[slot];
               cache_valid[slot] = 1'b0;
               cache_count--;
            end
         end
         if (slot < 0) begin
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
               if (slot < 0 && !cache_valid[i]) slot = i;
            end
         end
         if (slot >= 0) begin
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
               if (cache_valid[i]) cache_age[i]++;
            end
            cache_valid[slot] = 1'b1;
            cache_key[slot]   = key;
            cache_value[slot] = value;
            cache_age[slot]   = 0;
            cache_count++;
         end
      end
      res.occupancy = cache_count[OCC_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [KEY_W-1:0] seen,
                                  logic [KEY_W-1:0] ref_val);
      error_count++;
      $display("[%0t] beat %0d: %s got 0x%0h, predicted 0x%0h", $realtime, result_count,
               field, seen, ref_val);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         got = '{rsp_hit, rsp_read_value, rsp_evicted, rsp_evicted_key, rsp_evicted_value,
                 rsp_occupancy};
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat", got.evicted_key, '0);
         end else begin
            want = pending_results.pop_front();
            if (got.hit !== want.hit)
               report_mismatch("hit", KEY_W'(got.hit), KEY_W'(want.hit));
            if (got.read_value !== want.read_value)
               report_mismatch("read_value", KEY_W'(got.read_value), KEY_W'(want.read_value));
            if (got.evicted !== want.evicted)
               report_mismatch("evicted", KEY_W'(got.evicted), KEY_W'(want.evicted));
            if (got.evicted_key !== want.evicted_key)
               report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
            if (got.evicted_value !== want.evicted_value)
               report_mismatch("evicted_value", KEY_W'(got.evicted_value),
                               KEY_W'(want.evicted_value));
            if (got.occupancy !== want.occupancy)
               report_mismatch("occupancy", KEY_W'(got.occupancy), KEY_W'(want.occupancy));
            if (want.hit) hit_count++;
            if (want.evicted) eviction_count++;
         end
         result_count++;
      end
   end

   task automatic send_request(logic cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
      @(negedge clock);
      start     = 1'b1;
      req_cmd   = cmd;
      req_key   = key;
      req_value = value;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_access(cmd, key, value));
   endtask

   // Bursts of back-to-back beats separated by random gaps.
   task automatic issue_request(logic cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      send_request(cmd, key, value);
      burst_left--;
   endtask

   task automatic drain_results();
      int waited;
      @(negedge clock);
      start = 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         report_mismatch("results never delivered", KEY_W'(pending_results.size()), '0);
         pending_results.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      drain_results();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = cap;
      @(posedge clock);
      cache_capacity = cap;
      capacity_writes++;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] random_key(int span);
      if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
      return key_pool[$urandom_range(0, span - 1)];
   endfunction

   task automatic test_get_on_empty();
      send_request(lkvc_pkg::CMD_GET, '0, 32'h1234_5678);
      send_request(lkvc_pkg::CMD_GET, '1, '0);
   endtask

   task automatic test_field_extremes();
      send_request(lkvc_pkg::CMD_INSERT, '0, 32'h8000_0000);
      send_request(lkvc_pkg::CMD_INSERT, '1, 32'h7FFF_FFFF);
      send_request(lkvc_pkg::CMD_GET, '0, '1);
      send_request(lkvc_pkg::CMD_GET, '1, '0);
      send_request(lkvc_pkg::CMD_INSERT, '1, '0);
      send_request(lkvc_pkg::CMD_GET, '1, '0);
      send_request(lkvc_pkg::CMD_INSERT, 64'hA5A5_5A5A_0F0F_F0F0, 32'hFFFF_FFFF);
   endtask

   task automatic test_capacity_extremes();
      write_capacity(5'd1);
      send_request(lkvc_pkg::CMD_INSERT, 64'h0000_0000_0000_0011, 32'h0000_0011);
      send_request(lkvc_pkg::CMD_INSERT, 64'h0000_0000_0000_0022, 32'h0000_0022);
      send_request(lkvc_pkg::CMD_GET, 64'h0000_0000_0000_0011, '0);
      send_request(lkvc_pkg::CMD_INSERT, 64'h0000_0000_0000_0033, 32'h0000_0033);
      write_capacity(5'd0);
      send_request(lkvc_pkg::CMD_INSERT, 64'h0000_0000_0000_0044, 32'h0000_0044);
      send_request(lkvc_pkg::CMD_GET, 64'h0000_0000_0000_0044, '0);
      write_capacity(5'd31);
      send_request(lkvc_pkg::CMD_INSERT, 64'h0000_0000_0000_0055, 32'h0000_0055);
      send_request(lkvc_pkg::CMD_INSERT, 64'h0000_0000_0000_0066, 32'h0000_0066);
      send_request(lkvc_pkg::CMD_GET, 64'h0000_0000_0000_0011, '0);
   endtask

   task automatic test_random_traffic();
      logic [CAP_W-1:0] phase_caps [9];
      int span;
      logic cmd;
      phase_caps = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd5, 5'd17, 5'd1, 5'd0, 5'd16};
      phase_caps[7] = CAP_W'($urandom_range(0, 31));
      for (int p = 0; p < 9; p++) begin
         write_capacity(phase_caps[p]);
         span = effective_capacity() + 4;
         if (span > KEY_POOL_SIZE) span = KEY_POOL_SIZE;
         burst_left = 0;
         for (int n = 0; n < 62; n++) begin
            if (p == 3 && n == 30) drain_results();
            cmd = $urandom_range(0, 1) ? lkvc_pkg::CMD_INSERT : lkvc_pkg::CMD_GET;
            issue_request(cmd, random_key(span), random_value());
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_cmd     = lkvc_pkg::CMD_GET;
      req_key     = '0;
      req_value   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      error_count = 0;
      result_count = 0;
      hit_count = 0;
      eviction_count = 0;
      capacity_writes = 0;
      burst_left = 0;
      cache_count = 0;
      cache_capacity = lkvc_pkg::CAP_RESET;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         cache_valid[i] = 1'b0;
         cache_age[i]   = 0;
         cache_key[i]   = '0;
         cache_value[i] = '0;
      end
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_get_on_empty();
      test_field_extremes();
      test_capacity_extremes();
      test_random_traffic();
      drain_results();

      $display("Checked %0d result beats: %0d hits, %0d evictions, %0d capacity writes.",
               result_count, hit_count, eviction_count, capacity_writes);
      if (error_count == 0) begin
         $display("lru_key_value_cache_core: match");
      end else begin
         $display("lru_key_value_cache_core: mismatch");
      end
      $finish;
   end

endmodule
